// File: rtl/ibe_pkg.sv
package ibe_pkg;

    // width of the per-unit tick counter
    localparam int TICK_COUNT_WIDTH = 16;

    // configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TICKS_PER_UNIT = 1'd0,
        CFG_ACK_TIMEOUT    = 1'd1
    } t_cfg_index;

    localparam logic [15:0] TICKS_PER_UNIT_RESET = 16'd100;
    localparam logic [7:0]  ACK_TIMEOUT_RESET    = 8'd250;

    // command codes
    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_WRITE = 3'd3,
        OP_ACK   = 3'd4,
        OP_READ  = 3'd5
    } t_op;

    // delay lengths in units
    localparam logic [2:0] UNITS_4 = 3'd4;
    localparam logic [2:0] UNITS_2 = 3'd2;
    localparam logic [2:0] UNITS_1 = 3'd1;

    localparam logic [3:0] BYTE_BITS = 4'd8;

    // most phases that the chain may run within one tick
    localparam int RUN_STEPS = 3;

    // bus sequencer phases
    typedef enum logic [4:0] {
        PH_IDLE = 5'd0,
        PH_S0   = 5'd1,
        PH_S1   = 5'd2,
        PH_S2   = 5'd3,
        PH_P0   = 5'd4,
        PH_P1   = 5'd5,
        PH_P2   = 5'd6,
        PH_W0   = 5'd7,
        PH_W1   = 5'd8,
        PH_W2   = 5'd9,
        PH_W3   = 5'd10,
        PH_W4   = 5'd11,
        PH_A0   = 5'd12,
        PH_A1   = 5'd13,
        PH_A2   = 5'd14,
        PH_R0   = 5'd15,
        PH_R1   = 5'd16,
        PH_R2   = 5'd17,
        PH_R3   = 5'd18,
        PH_K0   = 5'd19,
        PH_K1   = 5'd20,
        PH_K2   = 5'd21
    } t_phase;

    // one tick in
    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] data_byte;
        logic       send_ack;
        logic       sda_sample;
    } t_item;

    // one tick out
    typedef struct packed {
        logic       scl_level;
        logic       sda_out_enable;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       ack_missing;
    } t_result;

endpackage

// File: rtl/i2c_master_bit_engine.sv
// I2C master bit engine.
// Input channel: one word per bus timer tick. A word carries an optional
// command (start, stop, write byte, wait ack, read byte) and the sampled
// SDA level. Commands given while a command runs are ignored.
// Output channel: one word per input word with the SCL/SDA drive levels,
// busy, a one-tick done pulse, the last read byte and the ack-missing flag,
// all as they stand after that tick.
// The result word is registered: output register, or skid entry while the
// result stalls. Throughput: one word per cycle unless o_in_stall is high;
// the sequencer update for a tick is a single pass of logic from the state
// registers to the result. Two output entries (output register plus skid
// entry) let one more word in while a result is stalled; a word taken while
// the result word stalls fills the skid entry and raises o_in_stall from the
// next cycle until the result word is taken and the skid entry moves up.
// Configuration: i_cfg_we writes ticks_per_unit (index 0) or ack_timeout
// (index 1); a write takes effect at once.
// Reset (synchronous, i_rst_n low): sequencer idle, SCL/SDA released high
// with SDA driven, both output entries empty, registers back to 100
// ticks per unit and an ack timeout of 250.
module i2c_master_bit_engine (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  ibe_pkg::t_item                      i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output ibe_pkg::t_result                    o_out_item,
    input  logic                                i_cfg_we,
    input  logic [ibe_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [ibe_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int TW = ibe_pkg::TICK_COUNT_WIDTH;

    // configuration registers
    logic [15:0] r_ticks_per_unit;
    logic [7:0]  r_ack_timeout;

    // sequencer state
    ibe_pkg::t_phase r_phase,         n_phase;
    logic [TW-1:0]   r_tick_count,    n_tick_count;
    logic [2:0]      r_unit_count,    n_unit_count;
    logic [3:0]      r_bit_index,     n_bit_index;
    logic [7:0]      r_shift_byte,    n_shift_byte;
    logic [7:0]      r_poll_count,    n_poll_count;
    logic            r_scl,           n_scl;
    logic            r_sda,           n_sda;
    logic            r_sda_oe,        n_sda_oe;
    logic            r_ack_choice,    n_ack_choice;
    logic [7:0]      r_received_byte, n_received_byte;
    logic            r_ack_flag,      n_ack_flag;
    logic            n_done;

    // output buffer
    logic              r_out_valid;
    ibe_pkg::t_result  r_out_item;
    logic              r_skid_valid;
    ibe_pkg::t_result  r_skid_item;
    ibe_pkg::t_result  n_result;

    logic w_accept;
    logic w_take;

    assign o_in_stall  = r_skid_valid;
    assign w_accept    = i_in_valid && !r_skid_valid;
    assign w_take      = r_out_valid && !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks_per_unit <= ibe_pkg::TICKS_PER_UNIT_RESET;
            r_ack_timeout    <= ibe_pkg::ACK_TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            case (ibe_pkg::t_cfg_index'(i_cfg_index))
                ibe_pkg::CFG_TICKS_PER_UNIT: r_ticks_per_unit <= i_cfg_data[15:0];
                ibe_pkg::CFG_ACK_TIMEOUT:    r_ack_timeout    <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // next state for one tick: command entry or delay countdown, then the phase chain
    always_comb begin
        ibe_pkg::t_phase v_phase;
        logic            v_run;
        logic [TW-1:0]   v_next;
        logic [15:0]     v_limit;

        n_phase         = r_phase;
        n_tick_count    = r_tick_count;
        n_unit_count    = r_unit_count;
        n_bit_index     = r_bit_index;
        n_shift_byte    = r_shift_byte;
        n_poll_count    = r_poll_count;
        n_scl           = r_scl;
        n_sda           = r_sda;
        n_sda_oe        = r_sda_oe;
        n_ack_choice    = r_ack_choice;
        n_received_byte = r_received_byte;
        n_ack_flag      = r_ack_flag;
        n_done          = 1'b0;
        v_phase         = r_phase;
        v_run           = 1'b0;
        v_next          = r_tick_count + TW'(1);
        v_limit         = (r_ticks_per_unit == 16'd0) ? 16'd1 : r_ticks_per_unit;

        // command entry or delay countdown
        if (r_phase == ibe_pkg::PH_IDLE) begin
            case (ibe_pkg::t_op'(i_in_item.operation))
                ibe_pkg::OP_START: begin
                    v_phase = ibe_pkg::PH_S0;
                    v_run   = 1'b1;
                end
                ibe_pkg::OP_STOP: begin
                    v_phase = ibe_pkg::PH_P0;
                    v_run   = 1'b1;
                end
                ibe_pkg::OP_WRITE: begin
                    n_shift_byte = i_in_item.data_byte;
                    v_phase      = ibe_pkg::PH_W0;
                    v_run        = 1'b1;
                end
                ibe_pkg::OP_ACK: begin
                    n_ack_flag = 1'b0;
                    v_phase    = ibe_pkg::PH_A0;
                    v_run      = 1'b1;
                end
                ibe_pkg::OP_READ: begin
                    n_ack_choice = i_in_item.send_ack;
                    v_phase      = ibe_pkg::PH_R0;
                    v_run        = 1'b1;
                end
                default: ;
            endcase
        end else if (r_unit_count != 3'd0) begin
            if ((32'(v_next) >= 32'(v_limit)) || (v_next == '0)) begin
                n_tick_count = '0;
                n_unit_count = r_unit_count - 3'd1;
                v_run        = (n_unit_count == 3'd0);
            end else begin
                n_tick_count = v_next;
            end
        end else begin
            v_run = 1'b1;
        end

        // phases that follow one another without a delay run in the same tick
        for (int k = 0; k < ibe_pkg::RUN_STEPS; k++) begin
            if (v_run) begin
                case (v_phase)
                    ibe_pkg::PH_S0: begin
                        n_sda_oe = 1'b1; n_sda = 1'b1; n_scl = 1'b1;
                        n_unit_count = ibe_pkg::UNITS_4; n_tick_count = '0;
                        n_phase = ibe_pkg::PH_S1; v_run = 1'b0;
                    end
                    ibe_pkg::PH_S1: begin
                        n_sda = 1'b0;
                        n_unit_count = ibe_pkg::UNITS_4; n_tick_count = '0;
                        n_phase = ibe_pkg::PH_S2; v_run = 1'b0;
                    end
                    ibe_pkg::PH_S2: begin
                        n_scl = 1'b0; v_phase = ibe_pkg::PH_IDLE;
                    end
                    ibe_pkg::PH_P0: begin
                        n_sda_oe = 1'b1; n_scl = 1'b0; n_sda = 1'b0;
                        n_unit_count = ibe_pkg::UNITS_4; n_tick_count = '0;
                        n_phase = ibe_pkg::PH_P1; v_run = 1'b0;
                    end
                    ibe_pkg::PH_P1: begin
                        n_scl = 1'b1; n_sda = 1'b1;
                        n_unit_count = ibe_pkg::UNITS_4; n_tick_count = '0;
                        n_phase = ibe_pkg::PH_P2; v_run = 1'b0;
                    end
                    ibe_pkg::PH_P2: begin
                        v_phase = ibe_pkg::PH_IDLE;
                    end
                    ibe_pkg::PH_W0: begin
                        n_sda_oe = 1'b1; n_scl = 1'b0; n_bit_index = 4'd0;
                        v_phase = ibe_pkg::PH_W1;
                    end
                    ibe_pkg::PH_W1: begin
                        n_sda        = n_shift_byte[7];
                        n_shift_byte = {n_shift_byte[6:0], 1'b0};
                        n_unit_count = ibe_pkg::UNITS_2; n_tick_count = '0;
                        n_phase = ibe_pkg::PH_W2; v_run = 1'b0;
                    end
                    ibe_pkg::PH_W2: begin
                        n_scl = 1'b1;
                        n_unit_count = ibe_pkg::UNITS_2; n_tick_count = '0;
                        n_phase = ibe_pkg::PH_W3; v_run = 1'b0;
                    end
                    ibe_pkg::PH_W3: begin
                        n_scl = 1'b0;
                        n_unit_count = ibe_pkg::UNITS_2; n_tick_count = '0;
                        n_phase = ibe_pkg::PH_W4; v_run = 1'b0;
                    end
                    ibe_pkg::PH_W4: begin
                        n_bit_index = n_bit_index + 4'd1;
                        v_phase = (n_bit_index < ibe_pkg::BYTE_BITS) ?
                                  ibe_pkg::PH_W1 : ibe_pkg::PH_IDLE;
                    end
                    ibe_pkg::PH_A0: begin
                        n_sda_oe = 1'b0; n_sda = 1'b1;
                        n_unit_count = ibe_pkg::UNITS_1; n_tick_count = '0;
                        n_phase = ibe_pkg::PH_A1; v_run = 1'b0;
                    end
                    ibe_pkg::PH_A1: begin
                        n_scl = 1'b1; n_poll_count = 8'd0;
                        n_unit_count = ibe_pkg::UNITS_1; n_tick_count = '0;
                        n_phase = ibe_pkg::PH_A2; v_run = 1'b0;
                    end
                    ibe_pkg::PH_A2: begin
                        // poll ack: low ends the wait, too many highs force a stop
                        if (!i_in_item.sda_sample) begin
                            n_scl = 1'b0; v_phase = ibe_pkg::PH_IDLE;
                        end else if (n_poll_count >= r_ack_timeout) begin
                            n_ack_flag = 1'b1; v_phase = ibe_pkg::PH_P0;
                        end else begin
                            n_poll_count = n_poll_count + 8'd1;
                            n_phase = ibe_pkg::PH_A2; n_unit_count = 3'd0;
                            v_run = 1'b0;
                        end
                    end
                    ibe_pkg::PH_R0: begin
                        n_sda_oe = 1'b0; n_bit_index = 4'd0; n_shift_byte = 8'd0;
                        v_phase = ibe_pkg::PH_R1;
                    end
                    ibe_pkg::PH_R1: begin
                        n_scl = 1'b0;
                        n_unit_count = ibe_pkg::UNITS_2; n_tick_count = '0;
                        n_phase = ibe_pkg::PH_R2; v_run = 1'b0;
                    end
                    ibe_pkg::PH_R2: begin
                        n_scl        = 1'b1;
                        n_shift_byte = {n_shift_byte[6:0], i_in_item.sda_sample};
                        n_unit_count = ibe_pkg::UNITS_1; n_tick_count = '0;
                        n_phase = ibe_pkg::PH_R3; v_run = 1'b0;
                    end
                    ibe_pkg::PH_R3: begin
                        n_bit_index = n_bit_index + 4'd1;
                        if (n_bit_index < ibe_pkg::BYTE_BITS) begin
                            v_phase = ibe_pkg::PH_R1;
                        end else begin
                            n_received_byte = n_shift_byte;
                            v_phase = ibe_pkg::PH_K0;
                        end
                    end
                    ibe_pkg::PH_K0: begin
                        n_scl = 1'b0; n_sda_oe = 1'b1; n_sda = !n_ack_choice;
                        n_unit_count = ibe_pkg::UNITS_2; n_tick_count = '0;
                        n_phase = ibe_pkg::PH_K1; v_run = 1'b0;
                    end
                    ibe_pkg::PH_K1: begin
                        n_scl = 1'b1;
                        n_unit_count = ibe_pkg::UNITS_2; n_tick_count = '0;
                        n_phase = ibe_pkg::PH_K2; v_run = 1'b0;
                    end
                    ibe_pkg::PH_K2: begin
                        n_scl = 1'b0; v_phase = ibe_pkg::PH_IDLE;
                    end
                    default: begin
                        // command complete
                        n_phase = ibe_pkg::PH_IDLE; n_unit_count = 3'd0;
                        n_tick_count = '0; n_done = 1'b1; v_run = 1'b0;
                    end
                endcase
            end
        end

        n_result.scl_level      = n_scl;
        n_result.sda_out_enable = n_sda_oe;
        n_result.sda_level      = n_sda;
        n_result.busy_res       = (n_phase != ibe_pkg::PH_IDLE);
        n_result.done_res       = n_done;
        n_result.read_data      = n_received_byte;
        n_result.ack_missing    = n_ack_flag;
    end

    // sequencer state registers, advanced once per accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= ibe_pkg::PH_IDLE;
            r_tick_count    <= '0;
            r_unit_count    <= 3'd0;
            r_bit_index     <= 4'd0;
            r_shift_byte    <= 8'd0;
            r_poll_count    <= 8'd0;
            r_scl           <= 1'b1;
            r_sda           <= 1'b1;
            r_sda_oe        <= 1'b1;
            r_ack_choice    <= 1'b0;
            r_received_byte <= 8'd0;
            r_ack_flag      <= 1'b0;
        end else if (w_accept) begin
            r_phase         <= n_phase;
            r_tick_count    <= n_tick_count;
            r_unit_count    <= n_unit_count;
            r_bit_index     <= n_bit_index;
            r_shift_byte    <= n_shift_byte;
            r_poll_count    <= n_poll_count;
            r_scl           <= n_scl;
            r_sda           <= n_sda;
            r_sda_oe        <= n_sda_oe;
            r_ack_choice    <= n_ack_choice;
            r_received_byte <= n_received_byte;
            r_ack_flag      <= n_ack_flag;
        end
    end

    // output register and skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_take || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_accept;
            end
        end else if (w_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    // payload of the output buffer
    always_ff @(posedge i_clk) begin
        if (w_take || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_item <= r_skid_item;
            end else if (w_accept) begin
                r_out_item <= n_result;
            end
        end else if (w_accept) begin
            r_skid_item <= n_result;
        end
    end

endmodule

// File: rtl/ibe_checker.sv
module ibe_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_stall,
    input ibe_pkg::t_item                   i_in_item,
    input logic                             o_out_valid,
    input logic                             i_out_stall,
    input ibe_pkg::t_result                 o_out_item,
    input logic                             i_cfg_we,
    input logic [ibe_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input logic [ibe_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    // reset empties the output buffer
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("output buffer not empty after reset");

    // input is held back only while a result word waits
    a_stall_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no result word pending");

    // done pulse comes only with the engine idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.done_res |-> !o_out_item.busy_res)
        else $error("done reported while busy");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result word changed");

endmodule

bind i2c_master_bit_engine ibe_checker u_ibe_checker (.*);
